/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the contour cell RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mscc_pkg.sv */
// Types, constants and the segment edge table of the contour cell unit.
package mscc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int FRAC_BITS = 8;

  localparam int SAMPLE_W = 16;
  localparam int ROWLEN_W = 11;
  localparam int COORD_W  = 18;
  localparam int CASE_W   = 4;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int QUOT_W   = FRAC_BITS + 1;
  localparam int DCNT_W   = $clog2(QUOT_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [ROWLEN_W-1:0] ROW_LEN_RESET = ROWLEN_W'(1024);
  localparam logic [ROWLEN_W-1:0] ROW_LEN_MIN   = ROWLEN_W'(2);

  localparam logic [CASE_W-1:0] CASE_NONE     = 4'd0;
  localparam logic [CASE_W-1:0] CASE_ALL      = 4'd15;
  localparam logic [CASE_W-1:0] CASE_SADDLE_A = 4'd5;
  localparam logic [CASE_W-1:0] CASE_SADDLE_B = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ISO_LEVEL  = 2'd0,
    CFG_ROW_LENGTH = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_TOP    = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [CASE_W-1:0]  cell_case;
    logic               last_of_cell;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  data;
  } cfg_t;

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] iso;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // Edge of endpoint j of segment k for a cell case.
  function automatic edge_e seg_edge(input logic [CASE_W-1:0] cs, input logic k,
                                     input logic j);
    edge_e e [4];
    case (cs)
      4'd1:    e = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
      4'd2:    e = '{EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
      4'd3:    e = '{EDGE_LEFT, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
      4'd4:    e = '{EDGE_TOP, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
      4'd5:    e = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_TOP, EDGE_RIGHT};
      4'd6:    e = '{EDGE_TOP, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
      4'd7:    e = '{EDGE_LEFT, EDGE_TOP, EDGE_LEFT, EDGE_LEFT};
      4'd8:    e = '{EDGE_LEFT, EDGE_TOP, EDGE_LEFT, EDGE_LEFT};
      4'd9:    e = '{EDGE_TOP, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
      4'd10:   e = '{EDGE_LEFT, EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM};
      4'd11:   e = '{EDGE_TOP, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
      4'd12:   e = '{EDGE_LEFT, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
      4'd13:   e = '{EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
      4'd14:   e = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
      default: e = '{EDGE_LEFT, EDGE_LEFT, EDGE_LEFT, EDGE_LEFT};
    endcase
    return e[{k, j}];
  endfunction

endpackage

/* hw/rtl/mscc_line_store.sv */
// Previous-row line store: one write port, one registered read port.
module mscc_line_store (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [mscc_pkg::COL_W-1:0]     rd_addr_i,
  output logic [mscc_pkg::SAMPLE_W-1:0]  rd_data_o,
  input  logic                           wr_en_i,
  input  logic [mscc_pkg::COL_W-1:0]     wr_addr_i,
  input  logic [mscc_pkg::SAMPLE_W-1:0]  wr_data_i
);
  import mscc_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/mscc_divider.sv */
// Iterative radix-2 divider for the endpoint fraction w1 / (w1 + w2).
module mscc_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mscc_pkg::div_req_t  req_i,
  output mscc_pkg::div_rsp_t  rsp_o
);
  import mscc_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_SUM  = 3'b010,
    DV_ITER = 3'b100
  } dv_state_e;

  dv_state_e             state_q, state_d;
  logic [SAMPLE_W-1:0]   w1_q, w1_d, w2_q, w2_d;
  logic [SAMPLE_W:0]     den_q, den_d, rem_q, rem_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [DCNT_W-1:0]     cnt_q, cnt_d;
  logic                  done_q, done_d;

  logic signed [SAMPLE_W:0] diff_a, diff_b;
  logic [SAMPLE_W:0]        mag_a, mag_b;
  logic [SAMPLE_W+1:0]      trial;
  logic                     in_bit;
  logic                     fits;

  always_comb begin
    diff_a = {req_i.a[SAMPLE_W-1], req_i.a} - {req_i.iso[SAMPLE_W-1], req_i.iso};
    diff_b = {req_i.b[SAMPLE_W-1], req_i.b} - {req_i.iso[SAMPLE_W-1], req_i.iso};
    mag_a  = diff_a[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_a) : diff_a;
    mag_b  = diff_b[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_b) : diff_b;
    // Only the top numerator bit below the preload can be set: w1[0].
    in_bit = (cnt_q == DCNT_W'(QUOT_W - 1)) ? w1_q[0] : 1'b0;
    trial  = {rem_q, in_bit};
    fits   = trial >= {1'b0, den_q};
  end

  always_comb begin
    state_d = state_q;
    w1_d    = w1_q;
    w2_d    = w2_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          w1_d    = mag_a[SAMPLE_W-1:0];
          w2_d    = mag_b[SAMPLE_W-1:0];
          state_d = DV_SUM;
        end
      end
      DV_SUM: begin
        den_d   = {1'b0, w1_q} + {1'b0, w2_q};
        rem_d   = (SAMPLE_W+1)'(w1_q >> 1);
        quot_d  = '0;
        cnt_d   = DCNT_W'(QUOT_W - 1);
        state_d = DV_ITER;
      end
      DV_ITER: begin
        rem_d  = fits ? (SAMPLE_W+1)'(trial - {1'b0, den_q}) : trial[SAMPLE_W:0];
        quot_d = {quot_q[QUOT_W-2:0], fits};
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q   <= w1_d;
    w2_q   <= w2_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  // A zero divisor only arises on an uncrossed edge; answer zero there.
  assign rsp_o.done = done_q;
  assign rsp_o.quot = (den_q == '0) ? '0 : quot_q;

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_quot_range, rsp_o.done, rsp_o.quot <= QUOT_W'(1 << FRAC_BITS),
               "fraction above one")
  `ASSERT_NEXT(a_start_no_done, req_i.start && state_q == DV_IDLE, !rsp_o.done, "early done")
  `ASSERT_NEXT(a_done_pulse, rsp_o.done, !rsp_o.done, "done held past one cycle")

endmodule

/* hw/rtl/marching_squares_contour_cells_unit.sv */
// Top level of the marching-squares contour cell unit.
//
// Pixels enter on the in channel (in_valid_i / in_ready_o, payload in_data_i)
// in raster order; frame_start on a pixel makes it row 0, column 0. Each pixel
// outside row 0 and column 0 closes a 2x2 cell with the previous row, kept in
// a line store. A cell with corners on both sides of the iso level sends one
// segment request on the out channel (out_valid_o / out_ready_i, payload
// out_data_o); a saddle cell, inside only at two opposite corners, sends two,
// the last one flagged. Configuration writes arrive on cfg_valid_i /
// cfg_ready_o with cfg_data_i; cfg_ready_o is always high and writes are
// expected only while idle.
// Timing: one pixel at a time. A pixel that emits nothing goes from evaluation
// straight back to idle, where the next one can be accepted. Each endpoint is
// issued from a start state to the shared radix-2 divider and waits for its
// quotient; a segment is offered once both endpoints are done, and a saddle's
// second segment starts only after the first is taken. A stalled receiver
// holds the segment in the output register and the input waits.
// Reset clears counters, neighbor samples and registers (iso level 0, row length
// 1024); the line store is not cleared, so a frame's first row only fills it.
module marching_squares_contour_cells_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mscc_pkg::in_t         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mscc_pkg::out_t        out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  mscc_pkg::cfg_t        cfg_data_i
);
  import mscc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic signed [SAMPLE_W-1:0] iso_q;
  logic [ROWLEN_W-1:0]        row_len_q;
  logic [COL_W-1:0]           col_q, col_d, cur_col_q, cur_col_d;
  logic [ROW_W-1:0]           row_q, row_d, cur_row_q, cur_row_d;
  logic signed [SAMPLE_W-1:0] left_q, left_d, ul_q, ul_d, s_q, s_d;
  logic signed [SAMPLE_W-1:0] tl_q, tl_d, tr_q, tr_d, br_q, br_d, bl_q, bl_d;
  logic [CASE_W-1:0]          case_q, case_d;
  logic                       two_q, two_d;
  logic                       k_q, k_d, j_q, j_d;
  logic [COORD_W-1:0]         xs_q, xs_d, ys_q, ys_d;
  out_t                       out_q, out_d;

  logic                       in_acc, out_acc;
  logic signed [SAMPLE_W-1:0] above;
  logic [CASE_W-1:0]          cell_case;
  logic                       emit;
  logic [ROWLEN_W-1:0]        len_eff;
  logic                       row_end;
  edge_e                      cur_edge;
  logic [COL_W-1:0]           col_m1;
  logic [ROW_W-1:0]           row_m1;
  logic [COORD_W-1:0]         bx, by, one, frac, px, py;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic [SAMPLE_W-1:0]        rd_data;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Line store: read the column above at acceptance, write the new pixel back
  // in the evaluation cycle once the old value is captured.
  mscc_line_store u_line (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_data_i.frame_start ? '0 : col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == ST_EVAL),
    .wr_addr_i (cur_col_q),
    .wr_data_i (s_q)
  );

  assign above = rd_data;

  // Cell case and row bookkeeping in the evaluation cycle.
  always_comb begin
    cell_case = {ul_q <= iso_q, above <= iso_q, s_q <= iso_q, left_q <= iso_q};
    emit      = (cur_row_q != '0) && (cur_col_q != '0) &&
                (cell_case != CASE_NONE) && (cell_case != CASE_ALL);
    if (row_len_q < ROW_LEN_MIN) begin
      len_eff = ROW_LEN_MIN;
    end else if (32'(row_len_q) > MAX_WIDTH) begin
      len_eff = ROWLEN_W'(MAX_WIDTH);
    end else begin
      len_eff = row_len_q;
    end
    row_end = (32'(cur_col_q) + 32'd1) >= 32'(len_eff);
  end

  // Endpoint operands for the divider and coordinates of the result.
  always_comb begin
    cur_edge    = seg_edge(case_q, k_q, j_q);
    div_req.iso = iso_q;
    div_req.start = (state_q == ST_START);
    case (cur_edge)
      EDGE_LEFT:   begin div_req.a = tl_q; div_req.b = bl_q; end
      EDGE_TOP:    begin div_req.a = tl_q; div_req.b = tr_q; end
      EDGE_RIGHT:  begin div_req.a = tr_q; div_req.b = br_q; end
      EDGE_BOTTOM: begin div_req.a = bl_q; div_req.b = br_q; end
      default:     begin div_req.a = tl_q; div_req.b = bl_q; end
    endcase
    col_m1 = cur_col_q - 1'b1;
    row_m1 = cur_row_q - 1'b1;
    bx     = COORD_W'({col_m1, {FRAC_BITS{1'b0}}});
    by     = COORD_W'({row_m1, {FRAC_BITS{1'b0}}});
    one    = COORD_W'(1) << FRAC_BITS;
    frac   = COORD_W'(div_rsp.quot);
    case (cur_edge)
      EDGE_LEFT:   begin px = bx;        py = by + frac; end
      EDGE_TOP:    begin px = bx + frac; py = by;        end
      EDGE_RIGHT:  begin px = bx + one;  py = by + frac; end
      EDGE_BOTTOM: begin px = bx + frac; py = by + one;  end
      default:     begin px = bx;        py = by;        end
    endcase
  end

  mscc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    left_d    = left_q;
    ul_d      = ul_q;
    s_d       = s_q;
    tl_d      = tl_q;
    tr_d      = tr_q;
    br_d      = br_q;
    bl_d      = bl_q;
    case_d    = case_q;
    two_d     = two_q;
    k_d       = k_q;
    j_d       = j_q;
    xs_d      = xs_q;
    ys_d      = ys_q;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          s_d       = in_data_i.sample;
          cur_col_d = in_data_i.frame_start ? '0 : col_q;
          cur_row_d = in_data_i.frame_start ? '0 : row_q;
          state_d   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        tl_d   = ul_q;
        tr_d   = above;
        br_d   = s_q;
        bl_d   = left_q;
        case_d = cell_case;
        two_d  = (cell_case == CASE_SADDLE_A) || (cell_case == CASE_SADDLE_B);
        k_d    = 1'b0;
        j_d    = 1'b0;
        ul_d   = above;
        left_d = s_q;
        // Advance column; wrap the row counter past the last row.
        if (row_end) begin
          col_d = '0;
          row_d = ((32'(cur_row_q) + 32'd1) >= MAX_ROWS) ? '0 : cur_row_q + 1'b1;
        end else begin
          col_d = cur_col_q + 1'b1;
          row_d = cur_row_q;
        end
        state_d = emit ? ST_START : ST_IDLE;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (!j_q) begin
            xs_d    = px;
            ys_d    = py;
            j_d     = 1'b1;
            state_d = ST_START;
          end else begin
            out_d.x_start      = xs_q;
            out_d.y_start      = ys_q;
            out_d.x_end        = px;
            out_d.y_end        = py;
            out_d.cell_case    = case_q;
            out_d.last_of_cell = k_q || !two_q;
            state_d            = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (k_q || !two_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = 1'b1;
            j_d     = 1'b0;
            state_d = ST_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iso_q     <= '0;
      row_len_q <= ROW_LEN_RESET;
      col_q     <= '0;
      row_q     <= '0;
      left_q    <= '0;
      ul_q      <= '0;
      k_q       <= 1'b0;
      j_q       <= 1'b0;
      two_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
      ul_q    <= ul_d;
      k_q     <= k_d;
      j_q     <= j_d;
      two_q   <= two_d;
      // Drop writes to indexes beyond the register list.
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_data_i.index)
          CFG_ISO_LEVEL:  iso_q     <= cfg_data_i.data;
          CFG_ROW_LENGTH: row_len_q <= cfg_data_i.data[ROWLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_col_q <= cur_col_d;
    cur_row_q <= cur_row_d;
    s_q       <= s_d;
    tl_q      <= tl_d;
    tr_q      <= tr_d;
    br_q      <= br_d;
    bl_q      <= bl_d;
    case_q    <= case_d;
    xs_q      <= xs_d;
    ys_q      <= ys_d;
    out_q     <= out_d;
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_out_blocks_in, out_valid_o, !in_ready_o, "input ready while a segment waits")
  `ASSERT_NEXT(a_accept_eval, in_acc, state_q == ST_EVAL, "accepted pixel not evaluated")
  `ASSERT_IMPL(a_out_case, out_valid_o,
               (out_q.cell_case != CASE_NONE) && (out_q.cell_case != CASE_ALL),
               "segment from empty or full cell")
  `ASSERT_IMPL(a_div_idle_out, state_q == ST_OUT, !div_rsp.done, "divider result outside division")

endmodule
